[design/assert_macros.svh]
// assertion macros for the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock edge, off while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// implication with the consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   `ASSERT_CLK(label, clk, rst, (ante) |-> (cons), msg)

// implication with the consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   `ASSERT_CLK(label, clk, rst, (ante) |=> (cons), msg)

`endif

[design/dedpq_pkg.sv]
// shared constants, codes and helpers for the double-ended queue
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dedpq_pkg;

   localparam int DEPTH      = 64;
   localparam int ITEM_WIDTH = 32;
   localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int KIND_W     = 2;
   localparam int STATUS_W   = 3;
   localparam int TOKEN_W    = 32;

   typedef enum logic [KIND_W-1:0] {
      KIND_APPEND = 2'd0,
      KIND_URGENT = 2'd1,
      KIND_REMOVE = 2'd2,
      KIND_LIST   = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ACCEPTED = 3'd0,
      ST_FULL     = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_REMOVED  = 3'd3,
      ST_LISTED   = 3'd4
   } status_type;

   typedef enum logic {
      S_IDLE   = 1'b0,
      S_STREAM = 1'b1
   } state_type;

   typedef logic [IDX_W-1:0]      idx_type;
   typedef logic [CNT_W-1:0]      cnt_type;
   typedef logic [ITEM_WIDTH-1:0] item_type;

   // next slot around the ring
   function automatic idx_type slot_inc(input idx_type p);
      return (p == idx_type'(DEPTH - 1)) ? '0 : idx_type'(p + 1'b1);
   endfunction

   // previous slot around the ring
   function automatic idx_type slot_dec(input idx_type p);
      return (p == '0) ? idx_type'(DEPTH - 1) : idx_type'(p - 1'b1);
   endfunction

   // base plus offset, offset at most DEPTH, so one subtract wraps it
   function automatic idx_type slot_add(input idx_type p, input cnt_type c);
      logic [CNT_W:0] s;
      s = (CNT_W + 1)'(p) + (CNT_W + 1)'(c);
      if (s >= (CNT_W + 1)'(DEPTH)) begin
         s = s - (CNT_W + 1)'(DEPTH);
      end
      return s[IDX_W-1:0];
   endfunction

   // port token to stored width
   function automatic item_type to_item(input logic [TOKEN_W-1:0] v);
      logic [63:0] t;
      t = 64'(v);
      return t[ITEM_WIDTH-1:0];
   endfunction

   // stored item to port token
   function automatic logic [TOKEN_W-1:0] to_token(input item_type v);
      logic [63:0] t;
      t = 64'(v);
      return t[TOKEN_W-1:0];
   endfunction

endpackage

`default_nettype wire

[design/double_ended_priority_queue_top.sv]
// double-ended queue top: ring of item tokens in one synchronous memory, depends on dedpq_pkg
// append, urgent insert and any full or empty answer reach the output register in the cycle
//    after the request is taken; a remove or the first listed item passes rd_data_ff first
// append and insert requests can be taken back to back while the output is free; a remove
//    or list holds req_stall high until its last result is loaded into the output register
// reset: synchronous, active high; clears head, count, state, stream pointers and output valid, not the memory
`timescale 1ns / 1ps
`default_nettype none

module double_ended_priority_queue_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request channel
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [dedpq_pkg::KIND_W-1:0]     req_kind,
   input  wire logic [dedpq_pkg::TOKEN_W-1:0]    req_item_in,
   // result channel
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [dedpq_pkg::STATUS_W-1:0]        rsp_status,
   output logic [dedpq_pkg::TOKEN_W-1:0]         rsp_item_out,
   output logic                                  rsp_last
);

   // control state
   dedpq_pkg::state_type state_ff, state_in;
   dedpq_pkg::idx_type   head_ff, head_in;
   dedpq_pkg::cnt_type   count_ff, count_in;
   dedpq_pkg::idx_type   rd_ptr_ff, rd_ptr_in;     // slot whose data sits in rd_data_ff
   dedpq_pkg::cnt_type   left_ff, left_in;         // results still owed, current one included
   logic                 listing_ff, listing_in;   // stream is a list, not a remove

   // output register
   logic                            rsp_valid_ff;
   dedpq_pkg::status_type           rsp_status_ff, rsp_status_in;
   logic [dedpq_pkg::TOKEN_W-1:0]   rsp_item_ff, rsp_item_in;
   logic                            rsp_last_ff, rsp_last_in;
   logic                            rsp_load;

   // entry memory, one write and one registered read port
   dedpq_pkg::item_type entry_mem [dedpq_pkg::DEPTH];
   dedpq_pkg::item_type rd_data_ff;
   logic                mem_we;
   dedpq_pkg::idx_type  mem_waddr;
   logic                mem_re;
   dedpq_pkg::idx_type  mem_raddr;

   // handshake
   logic                  out_free;
   logic                  req_accept;
   logic                  is_full;
   logic                  is_empty;
   dedpq_pkg::kind_type   kind;

   assign kind       = dedpq_pkg::kind_type'(req_kind);
   assign is_full    = (count_ff == dedpq_pkg::cnt_type'(dedpq_pkg::DEPTH));
   assign is_empty   = (count_ff == '0);
   // output slot can take a result this cycle
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   // requests only in idle, and only when the result has somewhere to go
   assign req_stall  = (state_ff != dedpq_pkg::S_IDLE) || !out_free;
   assign req_accept = req_valid && !req_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dedpq_pkg::S_IDLE: begin
            // remove and list wait for the memory read
            if (req_accept && !is_empty &&
                (kind == dedpq_pkg::KIND_REMOVE || kind == dedpq_pkg::KIND_LIST)) begin
               state_in = dedpq_pkg::S_STREAM;
            end
         end
         dedpq_pkg::S_STREAM: begin
            if (out_free && left_ff == dedpq_pkg::cnt_type'(1)) begin
               state_in = dedpq_pkg::S_IDLE;
            end
         end
         default: state_in = dedpq_pkg::S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      rd_ptr_in     = rd_ptr_ff;
      left_in       = left_ff;
      listing_in    = listing_ff;
      mem_we        = 1'b0;
      mem_waddr     = head_ff;
      mem_re        = 1'b0;
      mem_raddr     = head_ff;
      rsp_load      = 1'b0;
      rsp_status_in = dedpq_pkg::ST_ACCEPTED;
      rsp_item_in   = '0;
      rsp_last_in   = 1'b1;

      unique case (state_ff)
         dedpq_pkg::S_IDLE: begin
            if (req_accept) begin
               unique case (kind)
                  dedpq_pkg::KIND_APPEND: begin
                     rsp_load = 1'b1;
                     if (is_full) begin
                        rsp_status_in = dedpq_pkg::ST_FULL;
                     end else begin
                        // tail slot is head plus count around the ring
                        mem_we    = 1'b1;
                        mem_waddr = dedpq_pkg::slot_add(head_ff, count_ff);
                        count_in  = dedpq_pkg::cnt_type'(count_ff + 1'b1);
                     end
                  end
                  dedpq_pkg::KIND_URGENT: begin
                     rsp_load = 1'b1;
                     if (is_full) begin
                        rsp_status_in = dedpq_pkg::ST_FULL;
                     end else begin
                        // step head back, no entry moves
                        mem_we    = 1'b1;
                        mem_waddr = dedpq_pkg::slot_dec(head_ff);
                        head_in   = dedpq_pkg::slot_dec(head_ff);
                        count_in  = dedpq_pkg::cnt_type'(count_ff + 1'b1);
                     end
                  end
                  dedpq_pkg::KIND_REMOVE: begin
                     if (is_empty) begin
                        rsp_load      = 1'b1;
                        rsp_status_in = dedpq_pkg::ST_EMPTY;
                     end else begin
                        // read old head now, pointers move at once
                        mem_re     = 1'b1;
                        mem_raddr  = head_ff;
                        rd_ptr_in  = head_ff;
                        left_in    = dedpq_pkg::cnt_type'(1);
                        listing_in = 1'b0;
                        head_in    = dedpq_pkg::slot_inc(head_ff);
                        count_in   = dedpq_pkg::cnt_type'(count_ff - 1'b1);
                     end
                  end
                  dedpq_pkg::KIND_LIST: begin
                     if (is_empty) begin
                        rsp_load      = 1'b1;
                        rsp_status_in = dedpq_pkg::ST_EMPTY;
                     end else begin
                        mem_re     = 1'b1;
                        mem_raddr  = head_ff;
                        rd_ptr_in  = head_ff;
                        left_in    = count_ff;
                        listing_in = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         dedpq_pkg::S_STREAM: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_status_in = listing_ff ? dedpq_pkg::ST_LISTED : dedpq_pkg::ST_REMOVED;
               rsp_item_in   = dedpq_pkg::to_token(rd_data_ff);
               rsp_last_in   = (left_ff == dedpq_pkg::cnt_type'(1));
               // fetch the next slot while this result goes out
               if (left_ff != dedpq_pkg::cnt_type'(1)) begin
                  mem_re    = 1'b1;
                  mem_raddr = dedpq_pkg::slot_inc(rd_ptr_ff);
                  rd_ptr_in = dedpq_pkg::slot_inc(rd_ptr_ff);
                  left_in   = dedpq_pkg::cnt_type'(left_ff - 1'b1);
               end
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dedpq_pkg::S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rd_ptr_ff    <= '0;
         left_ff      <= '0;
         listing_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         head_ff    <= head_in;
         count_ff   <= count_in;
         rd_ptr_ff  <= rd_ptr_in;
         left_ff    <= left_in;
         listing_ff <= listing_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload, held while stalled
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_item_ff   <= rsp_item_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   // entry memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= dedpq_pkg::to_item(req_item_in);
      end
      if (mem_re) begin
         rd_data_ff <= entry_mem[mem_raddr];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_item_out = rsp_item_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

`default_nettype wire

[design/dedpq_checker.sv]
// port-level checks for the double-ended queue, bound to the top level
// depends on dedpq_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module dedpq_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_valid,
   input wire logic                             req_stall,
   input wire logic [dedpq_pkg::KIND_W-1:0]     req_kind,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_stall,
   input wire logic [dedpq_pkg::STATUS_W-1:0]   rsp_status,
   input wire logic [dedpq_pkg::TOKEN_W-1:0]    rsp_item_out,
   input wire logic                             rsp_last
);

   logic status_only;   // accepted, full or empty
   logic listed;
   logic remove_take;

   assign status_only = (rsp_status == dedpq_pkg::ST_ACCEPTED) ||
                        (rsp_status == dedpq_pkg::ST_FULL) ||
                        (rsp_status == dedpq_pkg::ST_EMPTY);
   assign listed      = (rsp_status == dedpq_pkg::ST_LISTED);
   assign remove_take = req_valid && !req_stall && (req_kind == dedpq_pkg::KIND_REMOVE);

   // a stalled result stays offered
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "result dropped")

   // only removed and listed results carry a token
   `ASSERT_IMPLY(a_item_zero, clock, reset, rsp_valid && status_only, rsp_item_out == '0, "token set")

   // every request except a list ends in one result
   `ASSERT_IMPLY(a_single_last, clock, reset, rsp_valid && !listed, rsp_last, "no last flag")

   // no request taken in the middle of a list
   `ASSERT_IMPLY(a_list_blocks, clock, reset, rsp_valid && !rsp_last, req_stall, "request open")

   // a remove of a held item answers only after the memory read
   `ASSERT_NEXT(a_remove_wait, clock, reset, remove_take, !rsp_valid || status_only, "early remove")

endmodule

bind double_ended_priority_queue_top dedpq_checker u_dedpq_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .req_kind     (req_kind),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_status   (rsp_status),
   .rsp_item_out (rsp_item_out),
   .rsp_last     (rsp_last)
);

`default_nettype wire

[tb/sv/tb_double_ended_priority_queue_top.sv]
// self-checking bench for the double-ended queue: directed table, then random request mix
// depends on dedpq_pkg and double_ended_priority_queue_top
`timescale 1ns / 1ps

module tb_double_ended_priority_queue_top;

   // one expected response beat
   typedef struct packed {
      dedpq_pkg::status_type             status;
      logic [dedpq_pkg::TOKEN_W-1:0]     token;
      logic                              last;
   } beat_type;

   // one line of the directed table; the answer is typed in only when it is obvious
   typedef struct packed {
      dedpq_pkg::kind_type               kind;
      logic [dedpq_pkg::TOKEN_W-1:0]     token;
      logic [7:0]                        reps;
      logic                              typed;
      dedpq_pkg::status_type             exp_status;
      logic [dedpq_pkg::TOKEN_W-1:0]     exp_item;
      logic                              exp_last;
   } plan_row_type;

   localparam int PLAN_ROWS = 19;

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                req_valid;
   logic                                req_stall;
   logic [dedpq_pkg::KIND_W-1:0]        req_kind;
   logic [dedpq_pkg::TOKEN_W-1:0]       req_item_in;
   logic                                rsp_valid;
   logic                                rsp_stall;
   logic [dedpq_pkg::STATUS_W-1:0]      rsp_status;
   logic [dedpq_pkg::TOKEN_W-1:0]       rsp_item_out;
   logic                                rsp_last;

   // shadow copy of the ring: slots, head slot and fill level
   dedpq_pkg::item_type                 ring_slots [dedpq_pkg::DEPTH];
   dedpq_pkg::idx_type                  ring_head;
   dedpq_pkg::cnt_type                  ring_fill;

   beat_type                            pending_beats [$];
   int                                  error_count = 0;

   always #4 clock = ~clock;

   double_ended_priority_queue_top DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_kind     (req_kind),
      .req_item_in  (req_item_in),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_item_out (rsp_item_out),
      .rsp_last     (rsp_last)
   );

   // mostly back to back, often a few cycles, now and then a long hole
   function automatic int idle_cycles(input bit quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) begin
         return 0;
      end
      if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 25);
   endfunction

   // advance the shadow ring by one request; queue its beats when asked to
   task automatic advance_ring(input dedpq_pkg::kind_type kind,
                               input logic [dedpq_pkg::TOKEN_W-1:0] token,
                               input bit keep);
      int slot;
      int i;
      beat_type beats [$];
      unique case (kind)
         dedpq_pkg::KIND_APPEND, dedpq_pkg::KIND_URGENT: begin
            if (int'(ring_fill) == dedpq_pkg::DEPTH) begin
               // no room, nothing moves
               beats.push_back(beat_type'{dedpq_pkg::ST_FULL, '0, 1'b1});
            end else begin
               if (kind == dedpq_pkg::KIND_URGENT) begin
                  // head steps back one slot, nothing shifts
                  ring_head = dedpq_pkg::idx_type'((int'(ring_head) + dedpq_pkg::DEPTH - 1)
                                                   % dedpq_pkg::DEPTH);
                  slot = int'(ring_head);
               end else begin
                  slot = (int'(ring_head) + int'(ring_fill)) % dedpq_pkg::DEPTH;
               end
               ring_slots[slot] = dedpq_pkg::item_type'(token);
               ring_fill = ring_fill + 1'b1;
               beats.push_back(beat_type'{dedpq_pkg::ST_ACCEPTED, '0, 1'b1});
            end
         end
         dedpq_pkg::KIND_REMOVE: begin
            if (ring_fill == '0) begin
               beats.push_back(beat_type'{dedpq_pkg::ST_EMPTY, '0, 1'b1});
            end else begin
               beats.push_back(beat_type'{dedpq_pkg::ST_REMOVED,
                  dedpq_pkg::TOKEN_W'(ring_slots[int'(ring_head)]), 1'b1});
               ring_head = dedpq_pkg::idx_type'((int'(ring_head) + 1) % dedpq_pkg::DEPTH);
               ring_fill = ring_fill - 1'b1;
            end
         end
         default: begin
            if (ring_fill == '0) begin
               beats.push_back(beat_type'{dedpq_pkg::ST_EMPTY, '0, 1'b1});
            end else begin
               // whole contents, head first, last flag on the tail entry
               for (i = 0; i < int'(ring_fill); i++) begin
                  slot = (int'(ring_head) + i) % dedpq_pkg::DEPTH;
                  beats.push_back(beat_type'{dedpq_pkg::ST_LISTED,
                     dedpq_pkg::TOKEN_W'(ring_slots[slot]), (i + 1 == int'(ring_fill))});
               end
            end
         end
      endcase
      if (keep) begin
         foreach (beats[b]) begin
            pending_beats.push_back(beats[b]);
         end
      end
   endtask

   // present one request after an optional gap, return at the edge that takes it
   task automatic send_request(input dedpq_pkg::kind_type kind,
                               input logic [dedpq_pkg::TOKEN_W-1:0] token,
                               input bit quiet);
      int gap;
      gap = idle_cycles(quiet);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_kind    <= kind;
      req_item_in <= token;
      do begin
         @(posedge clock);
      end while (req_stall);
   endtask

   // response checker: every beat taken is matched against the oldest expected one
   always @(posedge clock) begin : response_check
      beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_beats.size() == 0) begin
            $error("rsp: beat with nothing pending, status %0d item %h last %0b",
                   rsp_status, rsp_item_out, rsp_last);
            error_count++;
         end else begin
            want = pending_beats.pop_front();
            if (rsp_status !== want.status) begin
               $error("rsp_status: expected %0d, got %0d", want.status, rsp_status);
               error_count++;
            end
            if (rsp_item_out !== want.token) begin
               $error("rsp_item_out: expected %h, got %h", want.token, rsp_item_out);
               error_count++;
            end
            if (rsp_last !== want.last) begin
               $error("rsp_last: expected %0b, got %0b", want.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   // response side backpressure: stall bursts, free runs, and now and then a long clear stretch
   initial begin : response_backpressure
      int hold;
      rsp_stall = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         hold = idle_cycles(1'b0);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         hold = ($urandom_range(0, 19) == 0) ? 60 : $urandom_range(1, 8);
         repeat (hold) @(negedge clock);
      end
   end

   // hard stop well past the slowest legal run
   initial begin : run_limit
      #40_000_000;
      $display("tb_double_ended_priority_queue_top: done, errors");
      $finish;
   end

   initial begin : stimulus
      plan_row_type                  plan [PLAN_ROWS];
      dedpq_pkg::kind_type           kind;
      logic [dedpq_pkg::TOKEN_W-1:0] token;
      int                            n;
      int                            r;
      int                            rep;
      int                            phase;
      bit                            quiet;

      // empty answers first, then a short mix, then fill to the brim and drain it
      plan = '{
         '{dedpq_pkg::KIND_REMOVE, 32'hFFFF_0000, 8'd1, 1'b1, dedpq_pkg::ST_EMPTY,
           32'h0, 1'b1},
         '{dedpq_pkg::KIND_LIST, 32'hFFFF_FFFF, 8'd1, 1'b1, dedpq_pkg::ST_EMPTY,
           32'h0, 1'b1},
         '{dedpq_pkg::KIND_APPEND, 32'h0000_0000, 8'd1, 1'b1, dedpq_pkg::ST_ACCEPTED,
           32'h0, 1'b1},
         '{dedpq_pkg::KIND_APPEND, 32'hFFFF_FFFF, 8'd1, 1'b1, dedpq_pkg::ST_ACCEPTED,
           32'h0, 1'b1},
         '{dedpq_pkg::KIND_URGENT, 32'hA5A5_A5A5, 8'd1, 1'b1, dedpq_pkg::ST_ACCEPTED,
           32'h0, 1'b1},
         '{dedpq_pkg::KIND_LIST, 32'h0000_0000, 8'd1, 1'b0, dedpq_pkg::ST_LISTED,
           32'h0, 1'b0},
         '{dedpq_pkg::KIND_REMOVE, 32'h1234_5678, 8'd1, 1'b1, dedpq_pkg::ST_REMOVED,
           32'hA5A5_A5A5, 1'b1},
         '{dedpq_pkg::KIND_REMOVE, 32'h0000_0000, 8'd1, 1'b1, dedpq_pkg::ST_REMOVED,
           32'h0000_0000, 1'b1},
         '{dedpq_pkg::KIND_REMOVE, 32'h0000_0000, 8'd1, 1'b1, dedpq_pkg::ST_REMOVED,
           32'hFFFF_FFFF, 1'b1},
         '{dedpq_pkg::KIND_REMOVE, 32'h0000_0000, 8'd1, 1'b1, dedpq_pkg::ST_EMPTY,
           32'h0, 1'b1},
         // urgent insert into an empty ring
         '{dedpq_pkg::KIND_URGENT, 32'h1234_5678, 8'd1, 1'b1, dedpq_pkg::ST_ACCEPTED,
           32'h0, 1'b1},
         '{dedpq_pkg::KIND_APPEND, 32'h8000_0000, 8'd62, 1'b0, dedpq_pkg::ST_ACCEPTED,
           32'h0, 1'b1},
         '{dedpq_pkg::KIND_URGENT, 32'h5A5A_5A5A, 8'd1, 1'b1, dedpq_pkg::ST_ACCEPTED,
           32'h0, 1'b1},
         // ring is full: both insert kinds bounce
         '{dedpq_pkg::KIND_APPEND, 32'hDEAD_BEEF, 8'd1, 1'b1, dedpq_pkg::ST_FULL,
           32'h0, 1'b1},
         '{dedpq_pkg::KIND_URGENT, 32'hCAFE_F00D, 8'd1, 1'b1, dedpq_pkg::ST_FULL,
           32'h0, 1'b1},
         '{dedpq_pkg::KIND_LIST, 32'h0000_0000, 8'd1, 1'b0, dedpq_pkg::ST_LISTED,
           32'h0, 1'b0},
         '{dedpq_pkg::KIND_REMOVE, 32'h0000_0000, 8'd1, 1'b1, dedpq_pkg::ST_REMOVED,
           32'h5A5A_5A5A, 1'b1},
         '{dedpq_pkg::KIND_URGENT, 32'h0000_0001, 8'd1, 1'b1, dedpq_pkg::ST_ACCEPTED,
           32'h0, 1'b1},
         // drain everything and one more to see the empty answer again
         '{dedpq_pkg::KIND_REMOVE, 32'h0000_0000, 8'd65, 1'b0, dedpq_pkg::ST_REMOVED,
           32'h0, 1'b0}
      };

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_kind    = dedpq_pkg::KIND_APPEND;
      req_item_in = '0;
      ring_head   = '0;
      ring_fill   = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      foreach (plan[i]) begin
         for (rep = 0; rep < int'(plan[i].reps); rep++) begin
            token = plan[i].token + dedpq_pkg::TOKEN_W'(rep);
            send_request(plan[i].kind, token, 1'b0);
            if (plan[i].typed) begin
               advance_ring(plan[i].kind, token, 1'b0);
               pending_beats.push_back(beat_type'{plan[i].exp_status, plan[i].exp_item,
                                                  plan[i].exp_last});
            end else begin
               advance_ring(plan[i].kind, token, 1'b1);
            end
         end
      end

      // random part: fill-heavy, mixed and drain-heavy stretches in turn, so the ring
      // runs full and empty several times with the head wrapping both ways
      for (n = 0; n < 280; n++) begin
         phase = (n / 60) % 3;
         quiet = ((n / 40) % 4 == 3);
         r = $urandom_range(0, 99);
         unique case (phase)
            0: kind = (r < 48) ? dedpq_pkg::KIND_APPEND : (r < 94) ? dedpq_pkg::KIND_URGENT :
                      (r < 97) ? dedpq_pkg::KIND_REMOVE : dedpq_pkg::KIND_LIST;
            1: kind = (r < 35) ? dedpq_pkg::KIND_APPEND : (r < 65) ? dedpq_pkg::KIND_URGENT :
                      (r < 92) ? dedpq_pkg::KIND_REMOVE : dedpq_pkg::KIND_LIST;
            default: kind = (r < 86) ? dedpq_pkg::KIND_REMOVE :
                            (r < 91) ? dedpq_pkg::KIND_APPEND :
                            (r < 95) ? dedpq_pkg::KIND_URGENT : dedpq_pkg::KIND_LIST;
         endcase
         r = $urandom_range(0, 99);
         token = (r < 5) ? '0 : (r < 10) ? '1 : dedpq_pkg::TOKEN_W'($urandom);
         send_request(kind, token, quiet);
         advance_ring(kind, token, 1'b1);
      end

      @(negedge clock);
      req_valid <= 1'b0;

      // let every pending beat come out, then watch a while for strays
      while (pending_beats.size() != 0) begin
         @(posedge clock);
      end
      repeat (40) @(posedge clock);

      if (error_count == 0) begin
         $display("tb_double_ended_priority_queue_top: done, clean");
      end else begin
         $display("tb_double_ended_priority_queue_top: done, errors");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+design
design/dedpq_pkg.sv
design/double_ended_priority_queue_top.sv
design/dedpq_checker.sv
tb/sv/tb_double_ended_priority_queue_top.sv
